// ===== rtl/core/rmfs_pkg.sv =====
package rmfs_pkg;

  // Chunk id characters that mark a frame chunk
  localparam logic [7:0] CharD = 8'h64;
  localparam logic [7:0] CharC = 8'h63;
  localparam logic [7:0] CharB = 8'h62;

  // Frame counter limit
  localparam int unsigned CountW = 29;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgBaseOffset   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegionLength = 1'b1;

  // Record kinds
  localparam logic KindFrame = 1'b0;
  localparam logic KindEnd   = 1'b1;

  // Event queue between the front and the back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One queue entry: the results that one byte caused
  typedef struct packed {
    logic              has_frame;
    logic              has_end;
    logic [31:0]       frame_offset;
    logic [31:0]       frame_size;
    logic [CountW-1:0] frame_index;
    logic [CountW-1:0] frame_total;
    logic              scan_status;
  } rmfs_entry_t;

  // Handshake between queue head and back end
  typedef struct packed {
    logic valid;
    logic pop;
  } rmfs_head_ctl_t;

endpackage

// ===== rtl/core/rmfs_front.sv =====
module rmfs_front
  import rmfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  output logic                push_o,
  output rmfs_entry_t         entry_o
);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhSkip    = 2'd1;
  localparam logic [1:0] PhStopped = 2'd2;

  logic [31:0]       base_q, rlen_q;
  logic [1:0]        phase_q, phase_d;
  logic [31:0]       pos_q, pos_d;
  logic [63:0]       shift_q, shift_d;
  logic [2:0]        seen_q, seen_d;
  logic [32:0]       skip_q, skip_d;
  logic [CountW-1:0] frames_q, frames_d;

  logic [32:0]       end_pos, next_pos, pad_sum, pad_len, skip_dec;
  logic [63:0]       shift_new;
  logic [31:0]       hdr_id, hdr_size;
  logic [33:0]       reach;
  logic              hdr_done, overrun, is_frame, is_last;
  logic [CountW-1:0] frames_nx;

  // Decode header and region end for the current byte
  always_comb begin
    end_pos   = (rlen_q == 32'd0) ? {1'b1, 32'd0} : {1'b0, rlen_q};
    next_pos  = {1'b0, pos_q} + 33'd1;
    shift_new = {data_byte_i, shift_q[63:8]};
    hdr_id    = shift_new[31:0];
    hdr_size  = shift_new[63:32];
    hdr_done  = (phase_q == PhHeader) && (seen_q == 3'd7);
    reach     = {1'b0, next_pos} + {2'b00, hdr_size};
    overrun   = reach > {1'b0, end_pos};
    is_frame  = hdr_done && !overrun && (hdr_id[23:16] == CharD) &&
                ((hdr_id[31:24] == CharC) || (hdr_id[31:24] == CharB));
    pad_sum   = {1'b0, hdr_size} + 33'd1;
    pad_len   = {pad_sum[32:1], 1'b0};
    skip_dec  = (skip_q != 33'd0) ? skip_q - 33'd1 : skip_q;
    is_last   = next_pos >= end_pos;
    frames_nx = (is_frame && (frames_q != CountMax)) ? frames_q + CountW'(1) : frames_q;
  end

  // Advance the scan state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    seen_d   = seen_q;
    skip_d   = skip_q;
    frames_d = frames_nx;
    case (phase_q)
      PhHeader: begin
        shift_d = shift_new;
        seen_d  = seen_q + 3'd1;
        if (hdr_done) begin
          shift_d = 64'd0;
          if (overrun) begin
            phase_d = PhStopped;
          end else begin
            skip_d  = pad_len;
            phase_d = (pad_len == 33'd0) ? PhHeader : PhSkip;
          end
        end
      end
      PhSkip: begin
        skip_d = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_d = PhHeader;
        end
      end
      default: ;
    endcase
    if (is_last) begin
      phase_d  = PhHeader;
      pos_d    = 32'd0;
      shift_d  = 64'd0;
      seen_d   = 3'd0;
      skip_d   = 33'd0;
      frames_d = '0;
    end else begin
      pos_d = next_pos[31:0];
    end
  end

  // Build the queue entry for this byte
  always_comb begin
    entry_o.has_frame    = is_frame;
    entry_o.has_end      = is_last;
    entry_o.frame_offset = base_q + next_pos[31:0];
    entry_o.frame_size   = hdr_size;
    entry_o.frame_index  = frames_q;
    entry_o.frame_total  = frames_nx;
    entry_o.scan_status  = (frames_nx == '0);
    push_o               = accept_i && (is_frame || is_last);
  end

  // Hold configuration and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 32'd0;
      rlen_q   <= 32'd1;
      phase_q  <= PhHeader;
      pos_q    <= 32'd0;
      shift_q  <= 64'd0;
      seen_q   <= 3'd0;
      skip_q   <= 33'd0;
      frames_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBaseOffset:   base_q <= cfg_data_i;
          CfgRegionLength: rlen_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        shift_q  <= shift_d;
        seen_q   <= seen_d;
        skip_q   <= skip_d;
        frames_q <= frames_d;
      end
    end
  end

endmodule

// ===== rtl/core/rmfs_queue.sv =====
module rmfs_queue
  import rmfs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rmfs_entry_t    entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output rmfs_entry_t    head_o
);

  rmfs_entry_t            slot_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   do_pop;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/rmfs_back.sv =====
module rmfs_back
  import rmfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmfs_entry_t       head_i,
  output rmfs_head_ctl_t    ctl_o,
  input  logic              head_valid_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              record_kind_o,
  output logic [31:0]       frame_offset_o,
  output logic [31:0]       frame_size_o,
  output logic [CountW-1:0] frame_index_o,
  output logic [CountW-1:0] frame_total_o,
  output logic              scan_status_o,
  output logic              last_of_run_o
);

  logic second_q;
  logic send_end, beat_done;

  // Pick the beat to show from the head entry
  always_comb begin
    send_end       = head_i.has_end && (!head_i.has_frame || second_q);
    out_valid_o    = head_valid_i;
    record_kind_o  = send_end ? KindEnd : KindFrame;
    frame_offset_o = send_end ? 32'd0 : head_i.frame_offset;
    frame_size_o   = send_end ? 32'd0 : head_i.frame_size;
    frame_index_o  = send_end ? '0 : head_i.frame_index;
    frame_total_o  = send_end ? head_i.frame_total : '0;
    scan_status_o  = send_end ? head_i.scan_status : 1'b0;
    last_of_run_o  = send_end || !head_i.has_end;
    beat_done      = head_valid_i && out_ready_i;
    ctl_o.valid    = beat_done;
    ctl_o.pop      = beat_done && last_of_run_o;
  end

  // Track the second beat of an entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (ctl_o.valid) begin
      second_q <= !ctl_o.pop;
    end
  end

endmodule

// ===== rtl/core/riff_movi_frame_scanner_core.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid_i, in_ready_o, data_byte_i       | byte stream in
// output  | out_valid_o, out_ready_i, record fields   | frame and end records out
// config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | register writes in
//         | cfg_data_i                                |
//
// One byte is taken per cycle; its state update finishes in the same cycle.
// Each byte with results puts one entry into a four-deep queue; the back end
// sends one beat per cycle while out_ready_i is high; a byte with a frame and
// an end record gives two beats. Input stalls only while the queue is full.
// Reset clears the scan state, sets base_offset 0 and region_length 1.
module riff_movi_frame_scanner_core
  import rmfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               record_kind_o,
  output logic [31:0]        frame_offset_o,
  output logic [31:0]        frame_size_o,
  output logic [CountW-1:0]  frame_index_o,
  output logic [CountW-1:0]  frame_total_o,
  output logic               scan_status_o,
  output logic               last_of_run_o
);

  logic           accept, push, full, head_valid;
  rmfs_entry_t    entry, head;
  rmfs_head_ctl_t head_ctl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign accept      = in_valid_i && in_ready_o;

  rmfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (entry)
  );

  rmfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (head_ctl.pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rmfs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .ctl_o          (head_ctl),
    .head_valid_i   (head_valid),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_kind_o  (record_kind_o),
    .frame_offset_o (frame_offset_o),
    .frame_size_o   (frame_size_o),
    .frame_index_o  (frame_index_o),
    .frame_total_o  (frame_total_o),
    .scan_status_o  (scan_status_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rmfs_pkg::*;

  localparam int unsigned ItemTarget   = 1200;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailItems    = 150;

  typedef struct packed {
    logic              kind;
    logic [31:0]       offset;
    logic [31:0]       fsize;
    logic [CountW-1:0] fidx;
    logic [CountW-1:0] total;
    logic              status;
    logic              last;
  } record_t;

  typedef enum logic [1:0] {ScanHeader, ScanSkip, ScanStopped} scan_phase_e;
  typedef enum logic {RowByte, RowCfg} row_op_e;

  typedef struct packed {
    row_op_e            op;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    logic [1:0]         n_typed;
    record_t            r0;
    record_t            r1;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               record_kind_o;
  logic [31:0]        frame_offset_o;
  logic [31:0]        frame_size_o;
  logic [CountW-1:0]  frame_index_o;
  logic [CountW-1:0]  frame_total_o;
  logic               scan_status_o;
  logic               last_of_run_o;

  riff_movi_frame_scanner_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_kind_o  (record_kind_o),
    .frame_offset_o (frame_offset_o),
    .frame_size_o   (frame_size_o),
    .frame_index_o  (frame_index_o),
    .frame_total_o  (frame_total_o),
    .scan_status_o  (scan_status_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Scanner shadow state and registers
  logic [31:0]       cfg_base = '0;
  logic [31:0]       cfg_len = 32'd1;
  scan_phase_e       scan_ph = ScanHeader;
  logic [31:0]       scan_pos = '0;
  logic [63:0]       hdr_shift = '0;
  logic [2:0]        hdr_count = '0;
  logic [32:0]       skip_left = '0;
  logic [CountW-1:0] shadow_frames = '0;

  record_t     pending_records[$];
  stim_row_t   dir_tbl[$];
  logic [7:0]  region_bytes[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rand_sent = 0;
  bit          quiet_tail = 1'b0;
  bit          calm_phase = 1'b0;
  record_t     got_rec;
  record_t     want_rec;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic record_t frame_rec(logic [31:0] off, logic [31:0] sz,
                                        logic [CountW-1:0] ord, logic last);
    record_t r;
    r        = '0;
    r.kind   = KindFrame;
    r.offset = off;
    r.fsize  = sz;
    r.fidx   = ord;
    r.last   = last;
    return r;
  endfunction

  function automatic record_t end_rec(logic [CountW-1:0] total, logic last);
    record_t r;
    r        = '0;
    r.kind   = KindEnd;
    r.total  = total;
    r.status = (total == '0);
    r.last   = last;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b);
    return '{RowByte, '0, {24'h0, b}, 2'd0, '0, '0};
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    return '{RowCfg, idx, val, 2'd0, '0, '0};
  endfunction

  task automatic rearm_scan();
    scan_ph       = ScanHeader;
    scan_pos      = '0;
    hdr_shift     = '0;
    hdr_count     = '0;
    skip_left     = '0;
    shadow_frames = '0;
  endtask

  // Advance the shadow scanner by one byte and return the records it causes
  task automatic scan_byte(input logic [7:0] b, output record_t r0, output record_t r1,
                           output int n);
    logic [33:0] end_pos;
    logic [33:0] next_pos;
    logic [31:0] id;
    logic [31:0] sz;
    record_t     outs [0:1];
    n       = 0;
    outs[0] = '0;
    outs[1] = '0;
    end_pos  = (cfg_len == '0) ? 34'h1_0000_0000 : {2'b00, cfg_len};
    next_pos = {2'b00, scan_pos} + 34'd1;
    case (scan_ph)
      ScanHeader: begin
        hdr_shift = {b, hdr_shift[63:8]};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == 3'd0) begin
          id = hdr_shift[31:0];
          sz = hdr_shift[63:32];
          // Stop on a payload that runs past the region end
          if (next_pos + {2'b00, sz} > end_pos) begin
            scan_ph = ScanStopped;
          end else begin
            if (id[23:16] == CharD && (id[31:24] == CharC || id[31:24] == CharB)) begin
              outs[n] = frame_rec(cfg_base + next_pos[31:0], sz, shadow_frames, 1'b0);
              n++;
              if (shadow_frames != CountMax) shadow_frames = shadow_frames + 1'b1;
            end
            skip_left = ({1'b0, sz} + 33'd1) & ~33'd1;
            scan_ph   = (skip_left == '0) ? ScanHeader : ScanSkip;
          end
          hdr_shift = '0;
        end
      end
      ScanSkip: begin
        if (skip_left != '0) skip_left = skip_left - 33'd1;
        if (skip_left == '0) scan_ph = ScanHeader;
      end
      default: ;
    endcase
    // Close the region on its last byte
    if (next_pos >= end_pos) begin
      outs[n] = end_rec(shadow_frames, 1'b0);
      n++;
      rearm_scan();
    end else begin
      scan_pos = next_pos[31:0];
    end
    if (n > 0) outs[n-1].last = 1'b1;
    r0 = outs[0];
    r1 = outs[1];
  endtask

  // Queue the expected records, then hold the beat until it is taken
  task automatic send_byte(input logic [7:0] b, input logic [1:0] n_typed,
                           input record_t t0, input record_t t1);
    record_t p0;
    record_t p1;
    int      n;
    scan_byte(b, p0, p1, n);
    if (n_typed != 2'd0) begin
      pending_records.push_back(t0);
      if (n_typed == 2'd2) pending_records.push_back(t1);
    end else begin
      if (n > 0) pending_records.push_back(p0);
      if (n > 1) pending_records.push_back(p1);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (!quiet_tail && !calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Drop valid and let every expected record drain out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgBaseOffset) cfg_base = val;
    else if (idx == CfgRegionLength) cfg_len = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build one region: mostly frame chunks, some other ids and sizes, at times raw bytes
  task automatic make_region(input int unsigned len);
    int unsigned cur;
    int unsigned pick;
    int unsigned k;
    logic [31:0] sz;
    logic [7:0]  c2;
    logic [7:0]  c3;
    region_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      while (region_bytes.size() < len) region_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    while (region_bytes.size() < len) begin
      cur  = region_bytes.size();
      pick = $urandom_range(0, 9);
      c2   = CharD;
      c3   = (pick % 2 == 1) ? CharC : CharB;
      if (pick == 6) begin
        c2 = 8'h77;
        c3 = CharB;
      end else if (pick == 7) begin
        c3 = 8'($urandom_range(0, 255));
      end else if (pick == 8) begin
        c2 = 8'($urandom_range(0, 255));
      end else if (pick == 9) begin
        c2 = 8'($urandom_range(0, 255));
        c3 = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) sz = $urandom_range(0, 24);
      else if (pick == 7) sz = (len >= cur + 8) ? len - cur - 8 : 0;
      else if (pick == 8) sz = (len >= cur + 8) ? len - cur - 7 : 1;
      else sz = $urandom();
      region_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
      region_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
      region_bytes.push_back(c2);
      region_bytes.push_back(c3);
      region_bytes.push_back(sz[7:0]);
      region_bytes.push_back(sz[15:8]);
      region_bytes.push_back(sz[23:16]);
      region_bytes.push_back(sz[31:24]);
      // Payload plus the pad byte of an odd size
      k = 0;
      while (region_bytes.size() < len && (k < sz || k % 2 == 1)) begin
        region_bytes.push_back(8'($urandom_range(0, 255)));
        k++;
      end
    end
    while (region_bytes.size() > len) void'(region_bytes.pop_back());
  endtask

  task automatic load_directed();
    // Default length of one: every byte closes an empty region
    dir_tbl.push_back('{RowByte, '0, 32'h00, 2'd1, end_rec('0, 1'b1), '0});
    dir_tbl.push_back('{RowByte, '0, 32'hFF, 2'd1, end_rec('0, 1'b1), '0});
    // Zero-size frame whose header ends on the last byte, offset near the 32-bit top
    dir_tbl.push_back(cfg_row(CfgBaseOffset, 32'hFFFF_FFF0));
    dir_tbl.push_back(cfg_row(CfgRegionLength, 32'd8));
    dir_tbl.push_back(byte_row(8'h30));
    dir_tbl.push_back(byte_row(8'h30));
    dir_tbl.push_back(byte_row(CharD));
    dir_tbl.push_back(byte_row(CharC));
    dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back('{RowByte, '0, 32'h00, 2'd2,
                        frame_rec(32'hFFFF_FFF8, '0, '0, 1'b0),
                        end_rec(CountW'(1), 1'b1)});
    // Zero length means a full 4 GiB region; an oversized chunk stops the scan
    dir_tbl.push_back(cfg_row(CfgRegionLength, 32'd0));
    dir_tbl.push_back(byte_row(8'h30));
    dir_tbl.push_back(byte_row(8'h31));
    dir_tbl.push_back(byte_row(8'h77));
    dir_tbl.push_back(byte_row(CharB));
    dir_tbl.push_back(byte_row(8'hFF));
    dir_tbl.push_back(byte_row(8'hFF));
    dir_tbl.push_back(byte_row(8'hFF));
    dir_tbl.push_back(byte_row(8'hFF));
    // Shrink the length below the current position: next byte closes the region
    dir_tbl.push_back(cfg_row(CfgRegionLength, 32'd3));
    dir_tbl.push_back('{RowByte, '0, 32'h5A, 2'd1, end_rec('0, 1'b1), '0});
  endtask

  task automatic run_random();
    int unsigned phase_no;
    int unsigned fed;
    logic [31:0] base;
    logic [31:0] len;
    phase_no = 0;
    while (rand_sent < ItemTarget) begin
      if (phase_no == 0) base = '0;
      else if (phase_no == 1) base = 32'hFFFF_FFFF;
      else if ($urandom_range(0, 2) == 0) base = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else base = $urandom();
      if (phase_no == 2) len = 32'd1;
      else if (phase_no == 3) len = 32'hFFFF_FFFF;
      else if ($urandom_range(0, 4) == 0) len = 32'd8;
      else len = $urandom_range(9, 160);
      wait_idle();
      write_reg(CfgBaseOffset, base);
      write_reg(CfgRegionLength, len);
      calm_phase = ($urandom_range(0, 3) == 0);
      fed = 0;
      while (fed < 150 && rand_sent < ItemTarget) begin
        // Feed only part of a very long region; the next phase cuts it short
        make_region((len > 400) ? 300 : len);
        foreach (region_bytes[i]) begin
          send_byte(region_bytes[i], 2'd0, '0, '0);
          fed++;
          rand_sent++;
          quiet_tail = (rand_sent + TailItems >= ItemTarget);
          if (rand_sent >= ItemTarget) break;
        end
        if (len > 400) break;
      end
      phase_no++;
    end
  endtask

  task automatic note_mismatch(input string what, input record_t want, input record_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind=%0d off=%h size=%h idx=%0d total=%0d status=%0d last=%0d",
               what, want.kind, want.offset, want.fsize, want.fidx, want.total,
               want.status, want.last);
      $display("  got kind=%0d off=%h size=%h idx=%0d total=%0d status=%0d last=%0d",
               got.kind, got.offset, got.fsize, got.fidx, got.total, got.status, got.last);
    end
  endtask

  // Check each record beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_rec = '{record_kind_o, frame_offset_o, frame_size_o, frame_index_o,
                  frame_total_o, scan_status_o, last_of_run_o};
      if (pending_records.size() == 0) begin
        note_mismatch("unexpected record", '0, got_rec);
      end else begin
        want_rec = pending_records.pop_front();
        if (got_rec.kind !== want_rec.kind || got_rec.offset !== want_rec.offset ||
            got_rec.fsize !== want_rec.fsize || got_rec.fidx !== want_rec.fidx ||
            got_rec.total !== want_rec.total || got_rec.status !== want_rec.status ||
            got_rec.last !== want_rec.last) begin
          note_mismatch("record mismatch", want_rec, got_rec);
        end
      end
    end
  end

  // Stall the record side in random bursts, none in the tail
  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  initial begin
    rearm_scan();
    load_directed();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].op == RowCfg) begin
        wait_idle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        send_byte(dir_tbl[i].data[7:0], dir_tbl[i].n_typed, dir_tbl[i].r0, dir_tbl[i].r1);
      end
    end

    run_random();
    wait_idle();

    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
